// ===== rtl/core/bvg_pkg.sv =====
// bvg_pkg: shared widths, curve tables, register indexes and control structs
// for the battery voltage gauge; no dependencies
package bvg_pkg;

   localparam int ADC_W         = 12;
   localparam int RATIO_W       = 4;
   localparam int MV_W          = 15;
   localparam int PCT_W         = 7;
   localparam int SEG_W         = 4;
   localparam int DX_W          = 8;
   localparam int DY_W          = 4;
   localparam int PROD_W        = DX_W + DY_W;
   localparam int DEN_W         = 8;
   localparam int CURVE_POINTS  = 14;
   localparam int SAMPLE_COUNT_DEF = 8;

   localparam int CSR_ADDR_W    = 4;
   localparam int CSR_DATA_W    = 32;

   localparam logic [MV_W-1:0]    MV_MAX         = 15'd32767;
   localparam logic [RATIO_W-1:0] RATIO_RESET    = 4'd2;
   localparam logic [MV_W-1:0]    VALID_MIN_RESET = 15'd2500;
   localparam logic [MV_W-1:0]    VALID_MAX_RESET = 15'd4500;
   localparam logic [PCT_W-1:0]   PCT_EMPTY      = 7'd0;
   localparam logic [PCT_W-1:0]   PCT_FULL       = 7'd100;

   // register indexes on the csr port (word address)
   localparam logic [1:0] REG_DIVIDER_RATIO = 2'd0;
   localparam logic [1:0] REG_VALID_MIN     = 2'd1;
   localparam logic [1:0] REG_VALID_MAX     = 2'd2;

   // lithium-ion discharge curve
   localparam logic [MV_W-1:0] CURVE_MV [CURVE_POINTS] = '{
      15'd3300, 15'd3500, 15'd3600, 15'd3700, 15'd3750, 15'd3800, 15'd3850,
      15'd3900, 15'd3950, 15'd4000, 15'd4050, 15'd4100, 15'd4150, 15'd4200
   };
   localparam logic [PCT_W-1:0] CURVE_PCT [CURVE_POINTS] = '{
      7'd0, 7'd3, 7'd8, 7'd15, 7'd25, 7'd35, 7'd50,
      7'd60, 7'd70, 7'd78, 7'd85, 7'd92, 7'd97, 7'd100
   };

   typedef struct packed {
      logic [RATIO_W-1:0] divider_ratio;
      logic [MV_W-1:0]    valid_min_mv;
      logic [MV_W-1:0]    valid_max_mv;
   } cfg_type;

   typedef struct packed {
      logic load_in;
      logic accum;
      logic div_start;
      logic latch_avg;
      logic latch_seg;
      logic latch_mul;
      logic latch_pct;
      logic load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic batch_last;
      logic div_done;
   } dp_status_type;

endpackage

// ===== rtl/core/battery_voltage_gauge_top.sv =====
// battery_voltage_gauge_top: top level of the battery voltage gauge
// depends on bvg_pkg, bvg_csr, bvg_dpath (with bvg_div) and bvg_ctrl
//
//  channel   direction  handshake                 payload
//  req       in         req_valid / req_stall     req_adc_mv
//  rsp       out        rsp_valid / rsp_stall     rsp_battery_mv, rsp_reading_valid,
//                                                 rsp_charge_percent
//  csr       in/out     psel/penable, pready=1    paddr, pwdata, prdata
//
// each reading passes through capture, then scale and accumulate
// the last reading of a batch then goes through the average (reciprocal multiply),
// segment and product, the divider start, the 12-bit one-bit-per-cycle
// interpolation divider and its done flag, and the load of the output register
// before rsp_valid rises
// synchronous active-high reset clears the sequencer, sum, count and configuration registers
// a finished result sits in the output register; later readings are still
// taken while it is stalled, and the sequencer waits only when the next
// batch result is ready before the previous one has gone
module battery_voltage_gauge_top #(
   parameter int SAMPLE_COUNT = bvg_pkg::SAMPLE_COUNT_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // reading input
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [bvg_pkg::ADC_W-1:0]      req_adc_mv,
   // result output
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [bvg_pkg::MV_W-1:0]       rsp_battery_mv,
   output logic                           rsp_reading_valid,
   output logic [bvg_pkg::PCT_W-1:0]      rsp_charge_percent,
   // configuration
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [bvg_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [bvg_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [bvg_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import bvg_pkg::*;

   cfg_type       cfg;
   dp_cmd_type    cmd;
   dp_status_type status;

   // divider ratio and valid window
   bvg_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // sequencer: owns both handshakes, drives datapath commands
   bvg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic and output payload registers
   bvg_dpath #(
      .SAMPLE_COUNT (SAMPLE_COUNT)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .cmd                (cmd),
      .status             (status),
      .req_adc_mv         (req_adc_mv),
      .rsp_battery_mv     (rsp_battery_mv),
      .rsp_reading_valid  (rsp_reading_valid),
      .rsp_charge_percent (rsp_charge_percent)
   );

endmodule

// ===== rtl/core/bvg_csr.sv =====
// bvg_csr: configuration registers behind the apb-style port
// depends on bvg_pkg
module bvg_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [bvg_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [bvg_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [bvg_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready,
   output bvg_pkg::cfg_type                  cfg
);
   import bvg_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic [1:0] reg_index;
   logic       wr_en;

   assign reg_index  = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_index)
            REG_DIVIDER_RATIO: cfg_in.divider_ratio = csr_pwdata[RATIO_W-1:0];
            REG_VALID_MIN:     cfg_in.valid_min_mv  = csr_pwdata[MV_W-1:0];
            REG_VALID_MAX:     cfg_in.valid_max_mv  = csr_pwdata[MV_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_DIVIDER_RATIO: csr_prdata = CSR_DATA_W'(cfg_ff.divider_ratio);
         REG_VALID_MIN:     csr_prdata = CSR_DATA_W'(cfg_ff.valid_min_mv);
         REG_VALID_MAX:     csr_prdata = CSR_DATA_W'(cfg_ff.valid_max_mv);
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.divider_ratio <= RATIO_RESET;
         cfg_ff.valid_min_mv  <= VALID_MIN_RESET;
         cfg_ff.valid_max_mv  <= VALID_MAX_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/core/bvg_div.sv =====
// bvg_div: restoring divider, one quotient bit per cycle
// standalone, used for the curve interpolation
module bvg_div #(
   parameter int NUM_W = 16,
   parameter int DEN_W = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [NUM_W-1:0] quotient,
   output logic             done
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   shifted;
   logic [DEN_W:0]   diff;

   assign shifted  = {rem_ff, quo_ff[NUM_W-1]};
   assign diff     = shifted - {1'b0, den_ff};
   assign quotient = quo_ff;
   assign done     = done_ff;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // partial remainder stays below the divisor
         if (!diff[DEN_W]) begin
            rem_in = diff[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

endmodule

// ===== rtl/core/bvg_dpath.sv =====
// bvg_dpath: scaling, batch sum, average, curve segment and percent datapath
// depends on bvg_pkg and bvg_div
module bvg_dpath #(
   parameter int SAMPLE_COUNT = bvg_pkg::SAMPLE_COUNT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bvg_pkg::cfg_type              cfg,
   input  bvg_pkg::dp_cmd_type           cmd,
   output bvg_pkg::dp_status_type        status,
   input  logic [bvg_pkg::ADC_W-1:0]     req_adc_mv,
   output logic [bvg_pkg::MV_W-1:0]      rsp_battery_mv,
   output logic                          rsp_reading_valid,
   output logic [bvg_pkg::PCT_W-1:0]     rsp_charge_percent
);
   import bvg_pkg::*;

   localparam int IDX_W = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
   localparam int SUM_W = MV_W + IDX_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SAMPLE_COUNT - 1);
   // average by reciprocal multiply, exact for every sum below 2**SUM_W
   localparam int AVG_SHIFT = SUM_W + $clog2(SAMPLE_COUNT);
   localparam int MUL_W     = SUM_W + 2;
   localparam int AVGP_W    = SUM_W + MUL_W;
   localparam logic [MUL_W-1:0] AVG_MUL =
      MUL_W'(((64'd1 << AVG_SHIFT) + 64'(SAMPLE_COUNT) - 64'd1) / 64'(SAMPLE_COUNT));

   logic [ADC_W-1:0]         adc_ff;
   logic [ADC_W+RATIO_W-1:0] scaled_raw;
   logic [MV_W-1:0]          scaled;
   logic [SUM_W-1:0]         sum_ff;
   logic [IDX_W-1:0]         idx_ff;
   logic [AVGP_W-1:0]        avg_prod;
   logic [MV_W-1:0]          avg_ff;
   logic                     lo_ff, hi_ff, valid_ff;
   logic [SEG_W-1:0]         seg_ff, seg_k, seg_prev;
   logic [PROD_W-1:0]        prod_ff;
   logic [PCT_W-1:0]         base_ff, pct_ff;
   logic [DEN_W-1:0]         span_ff;
   logic [MV_W-1:0]          dx_full, span_full;
   logic [PCT_W-1:0]         dy_full, pct_sum;
   logic [PROD_W-1:0]        div_quo;
   logic                     batch_last;
   logic                     div_done;
   logic [MV_W-1:0]          rsp_mv_ff;
   logic                     rsp_valid_bit_ff;
   logic [PCT_W-1:0]         rsp_pct_ff;

   assign scaled_raw = adc_ff * cfg.divider_ratio;
   assign scaled = (scaled_raw > (ADC_W+RATIO_W)'(MV_MAX)) ? MV_MAX
                                                           : scaled_raw[MV_W-1:0];

   assign batch_last = (idx_ff == LAST_IDX);
   assign status     = '{batch_last: batch_last, div_done: div_done};

   assign avg_prod = AVGP_W'(sum_ff) * AVGP_W'(AVG_MUL);

   // first curve point at or above the average
   always_comb begin
      seg_k = SEG_W'(CURVE_POINTS - 1);
      for (int i = CURVE_POINTS - 1; i >= 1; i--) begin
         if (avg_ff <= CURVE_MV[i]) seg_k = SEG_W'(i);
      end
   end

   assign seg_prev  = seg_ff - 1'b1;
   assign dx_full   = avg_ff - CURVE_MV[seg_prev];
   assign dy_full   = CURVE_PCT[seg_ff] - CURVE_PCT[seg_prev];
   assign span_full = CURVE_MV[seg_ff] - CURVE_MV[seg_prev];

   bvg_div #(
      .NUM_W (PROD_W),
      .DEN_W (DEN_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .num      (prod_ff),
      .den      (span_ff),
      .quotient (div_quo),
      .done     (div_done)
   );

   assign pct_sum = base_ff + div_quo[PCT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         idx_ff <= '0;
      end else if (cmd.accum) begin
         sum_ff <= sum_ff + SUM_W'(scaled);
         idx_ff <= batch_last ? '0 : idx_ff + 1'b1;
      end else if (cmd.load_rsp) begin
         sum_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) adc_ff <= req_adc_mv;
      if (cmd.latch_avg) avg_ff <= avg_prod[AVG_SHIFT +: MV_W];
      if (cmd.latch_seg) begin
         seg_ff   <= seg_k;
         lo_ff    <= (avg_ff <= CURVE_MV[0]);
         hi_ff    <= (avg_ff >= CURVE_MV[CURVE_POINTS-1]);
         valid_ff <= (avg_ff >= cfg.valid_min_mv) && (avg_ff <= cfg.valid_max_mv);
      end
      if (cmd.latch_mul) begin
         // curve ends add nothing on top of the end value
         prod_ff <= (lo_ff || hi_ff) ? '0
                                     : dx_full[DX_W-1:0] * dy_full[DY_W-1:0];
         base_ff <= lo_ff ? PCT_EMPTY : (hi_ff ? PCT_FULL : CURVE_PCT[seg_prev]);
         span_ff <= span_full[DEN_W-1:0];
      end
      if (cmd.latch_pct) pct_ff <= valid_ff ? pct_sum : PCT_EMPTY;
      if (cmd.load_rsp) begin
         rsp_mv_ff        <= avg_ff;
         rsp_valid_bit_ff <= valid_ff;
         rsp_pct_ff       <= pct_ff;
      end
   end

   assign rsp_battery_mv     = rsp_mv_ff;
   assign rsp_reading_valid  = rsp_valid_bit_ff;
   assign rsp_charge_percent = rsp_pct_ff;

endmodule

// ===== rtl/core/bvg_ctrl.sv =====
// bvg_ctrl: sequencer for accumulate, average, interpolate and result hand-off
// depends on bvg_pkg
module bvg_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  bvg_pkg::dp_status_type status,
   output bvg_pkg::dp_cmd_type    cmd
);
   import bvg_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ACC,
      S_AVG,
      S_SEG,
      S_MUL,
      S_PCT_START,
      S_PCT_WAIT,
      S_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = S_ACC;
            end
         end
         S_ACC: begin
            cmd.accum = 1'b1;
            state_in  = status.batch_last ? S_AVG : S_IDLE;
         end
         S_AVG: begin
            cmd.latch_avg = 1'b1;
            state_in      = S_SEG;
         end
         S_SEG: begin
            cmd.latch_seg = 1'b1;
            state_in      = S_MUL;
         end
         S_MUL: begin
            cmd.latch_mul = 1'b1;
            state_in      = S_PCT_START;
         end
         S_PCT_START: begin
            cmd.div_start = 1'b1;
            state_in      = S_PCT_WAIT;
         end
         S_PCT_WAIT: begin
            if (status.div_done) begin
               cmd.latch_pct = 1'b1;
               state_in      = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
